FILE: rtl/utrrb_pkg.sv
`timescale 1ns / 1ps

package utrrb_pkg;

   // Default ring depth. Each ring holds at most depth minus one bytes.
   localparam int RING_DEPTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      CMD_HOST_WRITE = 2'd0,
      CMD_HOST_READ  = 2'd1,
      CMD_TX_DONE    = 2'd2,
      CMD_RX_BYTE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_TX_FULL  = 2'd1,
      ST_RX_EMPTY = 2'd2,
      ST_RX_DROP  = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       send_strobe;
      logic [7:0] send_byte;
      logic [7:0] read_byte;
      status_type status_code;
      logic       rx_available;
      logic       tx_busy;
   } rsp_type;

endpackage

FILE: rtl/uart_tx_rx_ring_buffers.sv
`timescale 1ns / 1ps
// Latency: the result beat of a command appears on the cycle right after the start beat.
// Throughput: one command per cycle; busy is tied low, and the receiver cannot stall.
// The figure is set by the single registered read port of each ring memory.
// Reset (synchronous, active high) empties both rings and idles the transmitter;
// ring contents are not cleared, since no entry is ever read before it is written.
module uart_tx_rx_ring_buffers #(
   parameter int RING_DEPTH = utrrb_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  utrrb_pkg::req_type  req_data,
   output logic                rsp_valid,
   output utrrb_pkg::rsp_type  rsp_data
);
   import utrrb_pkg::*;

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

   // Advance a ring index, wrapping from the last slot back to slot zero.
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      if (idx == LAST_IDX) begin
         return '0;
      end
      return idx + 1'b1;
   endfunction

   // Ring memories. Each one is written at one address and read at one
   // address per cycle, with the read data registered.
   logic [7:0] tx_store_ff [RING_DEPTH];
   logic [7:0] rx_store_ff [RING_DEPTH];
   logic [7:0] tx_rd_ff;
   logic [7:0] rx_rd_ff;

   // Ring pointers. The transmitter is busy while the write and current
   // indices differ; the receive ring is empty while its indices match.
   logic [IDX_W-1:0] tx_wr_ff, tx_wr_in;
   logic [IDX_W-1:0] tx_cur_ff, tx_cur_in;
   logic [IDX_W-1:0] rx_wr_ff, rx_wr_in;
   logic [IDX_W-1:0] rx_rd_idx_ff, rx_rd_idx_in;

   // Result register. The byte fields that come from a ring are completed
   // from the memory read registers on the output side.
   logic       valid_ff;
   logic       strobe_ff, strobe_in;
   logic [7:0] sbyte_ff;
   logic       sbyte_mem_ff, sbyte_mem_in;
   logic       rbyte_vld_ff, rbyte_vld_in;
   status_type status_ff, status_in;
   logic       rx_avail_ff;
   logic       tx_busy_ff;

   logic             accept;
   logic             tx_we;
   logic             rx_we;
   logic [IDX_W-1:0] tx_wr_next;
   logic [IDX_W-1:0] tx_cur_next;
   logic [IDX_W-1:0] rx_wr_next;
   logic [IDX_W-1:0] rx_rd_next;

   // Every command finishes in a single pass, so the block never holds off.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign tx_wr_next  = ring_next(tx_wr_ff);
   assign tx_cur_next = ring_next(tx_cur_ff);
   assign rx_wr_next  = ring_next(rx_wr_ff);
   assign rx_rd_next  = ring_next(rx_rd_idx_ff);

   // Command decode. Only one pointer and at most one ring entry change per
   // command. A read of a ring always targets a slot written on an earlier
   // cycle, so the memories need no write-to-read bypass.
   always_comb begin
      tx_wr_in     = tx_wr_ff;
      tx_cur_in    = tx_cur_ff;
      rx_wr_in     = rx_wr_ff;
      rx_rd_idx_in = rx_rd_idx_ff;
      strobe_in    = 1'b0;
      sbyte_mem_in = 1'b0;
      rbyte_vld_in = 1'b0;
      status_in    = ST_OK;
      tx_we        = 1'b0;
      rx_we        = 1'b0;
      case (req_data.command)
         CMD_HOST_WRITE: begin
            if (tx_wr_ff == tx_cur_ff) begin
               // Idle transmitter: store the byte and send it right away.
               tx_we     = 1'b1;
               strobe_in = 1'b1;
               tx_wr_in  = tx_wr_next;
            end else if (tx_wr_next == tx_cur_ff) begin
               status_in = ST_TX_FULL;
            end else begin
               tx_we    = 1'b1;
               tx_wr_in = tx_wr_next;
            end
         end
         CMD_HOST_READ: begin
            if (rx_wr_ff == rx_rd_idx_ff) begin
               status_in = ST_RX_EMPTY;
            end else begin
               rbyte_vld_in = 1'b1;
               rx_rd_idx_in = rx_rd_next;
            end
         end
         CMD_TX_DONE: begin
            // A done event on an idle transmitter is ignored.
            if (tx_wr_ff != tx_cur_ff) begin
               if (tx_cur_next != tx_wr_ff) begin
                  strobe_in    = 1'b1;
                  sbyte_mem_in = 1'b1;
                  tx_cur_in    = tx_cur_next;
               end else begin
                  tx_cur_in = tx_wr_ff;
               end
            end
         end
         CMD_RX_BYTE: begin
            if (rx_wr_next != rx_rd_idx_ff) begin
               rx_we    = 1'b1;
               rx_wr_in = rx_wr_next;
            end else begin
               status_in = ST_RX_DROP;
            end
         end
         default: begin
         end
      endcase
   end

   // Ring memories: write on the accepted beat, read every cycle.
   always_ff @(posedge clock) begin
      if (accept && tx_we) begin
         tx_store_ff[tx_wr_ff] <= req_data.data_byte;
      end
      if (accept && rx_we) begin
         rx_store_ff[rx_wr_ff] <= req_data.data_byte;
      end
      tx_rd_ff <= tx_store_ff[tx_cur_next];
      rx_rd_ff <= rx_store_ff[rx_rd_idx_ff];
   end

   // Control state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wr_ff     <= '0;
         tx_cur_ff    <= '0;
         rx_wr_ff     <= '0;
         rx_rd_idx_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         valid_ff <= accept;
         if (accept) begin
            tx_wr_ff     <= tx_wr_in;
            tx_cur_ff    <= tx_cur_in;
            rx_wr_ff     <= rx_wr_in;
            rx_rd_idx_ff <= rx_rd_idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         strobe_ff    <= strobe_in;
         sbyte_ff     <= req_data.data_byte;
         sbyte_mem_ff <= sbyte_mem_in;
         rbyte_vld_ff <= rbyte_vld_in;
         status_ff    <= status_in;
         rx_avail_ff  <= (rx_wr_in != rx_rd_idx_in);
         tx_busy_ff   <= (tx_wr_in != tx_cur_in);
      end
   end

   // Result beat. Byte fields read zero when they carry nothing.
   assign rsp_valid = valid_ff;

   always_comb begin
      rsp_data.send_strobe  = strobe_ff;
      rsp_data.send_byte    = '0;
      if (strobe_ff) begin
         rsp_data.send_byte = sbyte_mem_ff ? tx_rd_ff : sbyte_ff;
      end
      rsp_data.read_byte    = rbyte_vld_ff ? rx_rd_ff : 8'd0;
      rsp_data.status_code  = status_ff;
      rsp_data.rx_available = rx_avail_ff;
      rsp_data.tx_busy      = tx_busy_ff;
   end

endmodule

FILE: rtl/utrrb_checker.sv
`timescale 1ns / 1ps

module utrrb_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input utrrb_pkg::rsp_type rsp_data
);
   import utrrb_pkg::*;

   // Every accepted command gives exactly one result beat on the next cycle.
   a_rsp_follows_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("result beat missing after an accepted command");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result beat without an accepted command");

   // A rejected write never starts the transmitter.
   a_full_no_send: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status_code == ST_TX_FULL) |->
         (!rsp_data.send_strobe && rsp_data.tx_busy))
      else $error("send on a rejected write");

   // A read of an empty ring returns zero and leaves the ring empty.
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status_code == ST_RX_EMPTY) |->
         (rsp_data.read_byte == 8'd0 && !rsp_data.rx_available))
      else $error("empty read returned data or a nonempty ring");

   // A dropped byte means the receive ring is full, so it holds data.
   a_drop_has_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status_code == ST_RX_DROP) |-> rsp_data.rx_available)
      else $error("byte dropped while the receive ring reports empty");

endmodule

bind uart_tx_rx_ring_buffers utrrb_checker u_utrrb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

FILE: tb/sv/uart_ring_checker.sv
`timescale 1ns / 1ps

module uart_ring_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  utrrb_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  utrrb_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 outstanding
);
   import utrrb_pkg::*;

   localparam int DEPTH = RING_DEPTH_DEFAULT;

   logic [7:0] tx_ring [DEPTH];
   logic [7:0] rx_ring [DEPTH];
   int         tx_wr_ptr;
   int         tx_cur_ptr;
   int         rx_wr_ptr;
   int         rx_rd_ptr;
   rsp_type    expected_rsp_q[$];
   int         mismatches = 0;
   int         pending = 0;

   assign fail_count  = mismatches;
   assign outstanding = pending;

   function automatic int ring_advance(int idx);
      return (idx + 1 >= DEPTH) ? 0 : idx + 1;
   endfunction

   // Applies one command to the ring state and returns the beat it should produce.
   function rsp_type uart_ring_step(req_type req);
      rsp_type r;
      int      nxt;
      r = '0;
      r.status_code = ST_OK;
      case (req.command)
         CMD_HOST_WRITE: begin
            nxt = ring_advance(tx_wr_ptr);
            if (tx_wr_ptr == tx_cur_ptr) begin
               tx_ring[tx_wr_ptr] = req.data_byte;
               r.send_strobe = 1'b1;
               r.send_byte = req.data_byte;
               tx_wr_ptr = nxt;
            end else if (nxt == tx_cur_ptr) begin
               r.status_code = ST_TX_FULL;
            end else begin
               tx_ring[tx_wr_ptr] = req.data_byte;
               tx_wr_ptr = nxt;
            end
         end
         CMD_HOST_READ: begin
            if (rx_wr_ptr == rx_rd_ptr) begin
               r.status_code = ST_RX_EMPTY;
            end else begin
               r.read_byte = rx_ring[rx_rd_ptr];
               rx_rd_ptr = ring_advance(rx_rd_ptr);
            end
         end
         CMD_TX_DONE: begin
            if (tx_wr_ptr != tx_cur_ptr) begin
               nxt = ring_advance(tx_cur_ptr);
               if (nxt != tx_wr_ptr) begin
                  r.send_strobe = 1'b1;
                  r.send_byte = tx_ring[nxt];
                  tx_cur_ptr = nxt;
               end else begin
                  tx_cur_ptr = tx_wr_ptr;
               end
            end
         end
         CMD_RX_BYTE: begin
            nxt = ring_advance(rx_wr_ptr);
            if (nxt != rx_rd_ptr) begin
               rx_ring[rx_wr_ptr] = req.data_byte;
               rx_wr_ptr = nxt;
            end else begin
               r.status_code = ST_RX_DROP;
            end
         end
         default: begin
         end
      endcase
      r.rx_available = (rx_wr_ptr != rx_rd_ptr);
      r.tx_busy = (tx_wr_ptr != tx_cur_ptr);
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         tx_wr_ptr = 0;
         tx_cur_ptr = 0;
         rx_wr_ptr = 0;
         rx_rd_ptr = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               $error("Result beat arrived with no command waiting for one.");
               mismatches++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("send_strobe", 8'(want.send_strobe), 8'(rsp_data.send_strobe));
               check_field("send_byte", want.send_byte, rsp_data.send_byte);
               check_field("read_byte", want.read_byte, rsp_data.read_byte);
               check_field("status_code", 8'(want.status_code), 8'(rsp_data.status_code));
               check_field("rx_available", 8'(want.rx_available), 8'(rsp_data.rx_available));
               check_field("tx_busy", 8'(want.tx_busy), 8'(rsp_data.tx_busy));
            end
         end
         if (start && !busy) begin
            expected_rsp_q.push_back(uart_ring_step(req_data));
         end
      end
      pending <= expected_rsp_q.size();
   end

endmodule

FILE: tb/sv/tb_uart_tx_rx_ring_buffers.sv
`timescale 1ns / 1ps

module tb_uart_tx_rx_ring_buffers;
   import utrrb_pkg::*;

   // Traffic profiles for the random part. Each one but the even mix leans on one ring so that
   // the full and empty conditions and the index wrap are reached often.
   typedef enum int {
      MIX_EVEN,
      MIX_TX_FILL,
      MIX_TX_DRAIN,
      MIX_RX_FILL,
      MIX_RX_DRAIN
   } traffic_mix_type;

   localparam int RANDOM_ITEMS = 1550;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      outstanding;
   int      cycle_count = 0;
   logic    gaps_on = 1'b1;

   always #1 clock = ~clock;

   uart_tx_rx_ring_buffers dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // The checker watches both channels, predicts every result beat and
   // counts mismatches; this module only drives stimulus and decides.
   uart_ring_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Watchdog: a hung handshake or a missing result beat ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Presents one command beat. Inputs change only at the falling edge. When
   // idling is on, start may be dropped low first; with no gap, start
   // simply stays high from the previous beat, so it is never lowered and
   // raised in the same step. The beat is taken at the first rising edge
   // where busy is low.
   task automatic send_command(cmd_type cmd, logic [7:0] data);
      int gap;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_data.command = cmd;
      req_data.data_byte = data;
      do @(posedge clock); while (busy);
   endtask

   // Stops issuing and holds off until every predicted beat has come back.
   task automatic wait_for_quiet();
      @(negedge clock);
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic cmd_type pick_command(traffic_mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_TX_FILL:
            return roll < 75 ? CMD_HOST_WRITE : roll < 85 ? CMD_TX_DONE :
                   roll < 95 ? CMD_RX_BYTE : CMD_HOST_READ;
         MIX_TX_DRAIN:
            return roll < 15 ? CMD_HOST_WRITE : roll < 80 ? CMD_TX_DONE :
                   roll < 90 ? CMD_RX_BYTE : CMD_HOST_READ;
         MIX_RX_FILL:
            return roll < 75 ? CMD_RX_BYTE : roll < 85 ? CMD_HOST_READ :
                   roll < 95 ? CMD_HOST_WRITE : CMD_TX_DONE;
         MIX_RX_DRAIN:
            return roll < 70 ? CMD_HOST_READ : roll < 80 ? CMD_RX_BYTE :
                   roll < 90 ? CMD_HOST_WRITE : CMD_TX_DONE;
         default:
            return cmd_type'(roll % 4);
      endcase
   endfunction

   initial begin
      int              issued;
      int              block_len;
      int              block_idx;
      traffic_mix_type mix;

      // Reset is held from time zero and released on a falling edge.
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: the empty and idle corners first, then a short queue on
      // the transmit side, extreme data values on the receive side, and the
      // commands that must ignore their data byte.
      send_command(CMD_HOST_READ, 8'h00);   // read of an empty receive ring
      send_command(CMD_TX_DONE, 8'h00);     // transmitter done while idle
      send_command(CMD_HOST_WRITE, 8'h00);  // idle transmitter: sent at once
      send_command(CMD_HOST_WRITE, 8'hFF);  // busy transmitter: queued
      send_command(CMD_HOST_WRITE, 8'h5A);
      send_command(CMD_TX_DONE, 8'hFF);     // starts the queued 8'hFF
      send_command(CMD_TX_DONE, 8'h00);     // starts the queued 8'h5A
      send_command(CMD_TX_DONE, 8'hA5);     // nothing left, goes idle
      send_command(CMD_TX_DONE, 8'hFF);     // idle again, ignored
      send_command(CMD_RX_BYTE, 8'h00);
      send_command(CMD_RX_BYTE, 8'hFF);
      send_command(CMD_RX_BYTE, 8'hA5);
      send_command(CMD_HOST_READ, 8'hFF);   // data byte has no meaning here
      send_command(CMD_HOST_READ, 8'h00);
      send_command(CMD_HOST_READ, 8'h5A);
      send_command(CMD_HOST_READ, 8'hFF);   // empty once more
      send_command(CMD_HOST_WRITE, 8'hA5);
      send_command(CMD_TX_DONE, 8'h5A);

      // Random part, in blocks of one traffic profile each. Fill-heavy blocks
      // run the rings into their full cases and across the index wrap; drain
      // blocks bring them back to empty. Some blocks run with no gaps at all,
      // and every eighth block waits for the pipeline to go quiet first.
      issued = 0;
      block_idx = 0;
      while (issued < RANDOM_ITEMS) begin
         mix = traffic_mix_type'($urandom_range(0, 4));
         block_len = $urandom_range(30, 70);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (block_idx % 8 == 7) wait_for_quiet();
         repeat (block_len) begin
            send_command(pick_command(mix), 8'($urandom_range(0, 255)));
            issued++;
         end
         block_idx++;
      end

      // Let the last beats come home, with a bound, then run the spare DRAIN_CYCLES.
      @(negedge clock);
      start = 1'b0;
      repeat (100) begin
         if (outstanding != 0) @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
